### hdl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// shared types and constants of the motion stop detector
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int IDX_W        = 4;
  localparam int POS_W        = 24;
  localparam int THR_W        = 23;
  localparam int OUT_RUN_W    = 16;
  localparam int MAX_SENSORS_DEF = 16;
  localparam int RUN_W_DEF    = 16;

  // 3e-4 in q7.16, rounded
  localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(20);

  localparam logic EVT_STOPPED = 1'b0;
  localparam logic EVT_STARTED = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0]        sensor_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } msd_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]     event_sensor;
    logic                 event_kind;
    logic [OUT_RUN_W-1:0] run_length;
  } msd_out_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } msd_pos_t;

endpackage

### hdl/msd_ram.sv
// ----------------------------------------------------------------------------
// msd_ram
// single-port-write, single-port-read synchronous ram, registered read data
// ----------------------------------------------------------------------------
module msd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/msd_eval.sv
// ----------------------------------------------------------------------------
// msd_eval
// deadband compare and run counter update for one sample
// ----------------------------------------------------------------------------
module msd_eval #(
  parameter int RUN_W = 16
) (
  input  logic [msd_pkg::THR_W-1:0] thr_i,
  input  logic [msd_pkg::IDX_W-1:0] sensor_i,
  input  msd_pkg::msd_pos_t         pos_i,
  input  logic                      primed_i,
  input  msd_pkg::msd_pos_t         ref_i,
  input  logic [RUN_W-1:0]          move_i,
  input  logic [RUN_W-1:0]          still_i,
  output msd_pkg::msd_pos_t         ref_o,
  output logic [RUN_W-1:0]          move_o,
  output logic [RUN_W-1:0]          still_o,
  output logic                      evt_valid_o,
  output msd_pkg::msd_out_t         evt_o
);
  import msd_pkg::*;

  localparam int EXT_W = (RUN_W > OUT_RUN_W) ? RUN_W : OUT_RUN_W;

  function automatic logic [POS_W:0] abs_diff(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    logic [POS_W:0] d;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    return d[POS_W] ? (~d + (POS_W+1)'(1)) : d;
  endfunction

  function automatic logic [RUN_W-1:0] sat_inc(logic [RUN_W-1:0] v);
    return (&v) ? v : v + RUN_W'(1);
  endfunction

  function automatic logic [OUT_RUN_W-1:0] out_len(logic [RUN_W-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return (e > EXT_W'({OUT_RUN_W{1'b1}})) ? {OUT_RUN_W{1'b1}} : e[OUT_RUN_W-1:0];
  endfunction

  logic [POS_W:0] thr_ext;
  logic           still;

  assign thr_ext = (POS_W+1)'(thr_i);
  assign still   = (abs_diff(pos_i.x, ref_i.x) <= thr_ext) &&
                   (abs_diff(pos_i.y, ref_i.y) <= thr_ext) &&
                   (abs_diff(pos_i.z, ref_i.z) <= thr_ext);

  always_comb begin
    ref_o                 = ref_i;
    move_o                = move_i;
    still_o               = still_i;
    evt_valid_o           = 1'b0;
    evt_o.event_sensor    = sensor_i;
    evt_o.event_kind      = EVT_STOPPED;
    evt_o.run_length      = out_len(move_i);
    if (!primed_i) begin
      // first sample only loads the reference
      ref_o   = pos_i;
      move_o  = '0;
      still_o = '0;
    end else if (still) begin
      still_o = sat_inc(still_i);
      if (move_i != '0) begin
        evt_valid_o = 1'b1;
        move_o      = '0;
      end
    end else begin
      ref_o            = pos_i;
      move_o           = sat_inc(move_i);
      evt_o.event_kind = EVT_STARTED;
      evt_o.run_length = out_len(still_i);
      if (still_i != '0) begin
        evt_valid_o = 1'b1;
        still_o     = '0;
      end
    end
  end

endmodule

### hdl/motion_stop_detector.sv
// ----------------------------------------------------------------------------
// motion_stop_detector
// per-sensor deadband change detector with started and stopped events
// ----------------------------------------------------------------------------
// Takes one position request per clock unless stalled and gives at most one
// event request per sample, registered at the output. Per-sensor reference
// position and run counters sit in two synchronous rams that are read in the
// cycle a sample is taken and written back by stage one; a sample that hits
// the sensor written at that same edge takes the forwarded entry. Primed
// flags are flip-flops cleared by reset, so the block is ready right after
// reset with no clearing pass. Samples whose sensor index is at or above
// MAX_SENSORS are taken and dropped. The input stalls only while an event
// waits at the output and the next stage holds a sample.
module motion_stop_detector #(
  parameter int MAX_SENSORS = msd_pkg::MAX_SENSORS_DEF,
  parameter int RUN_W       = msd_pkg::RUN_W_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [msd_pkg::THR_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  msd_pkg::msd_in_t          in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output msd_pkg::msd_out_t         out_req_o
);
  import msd_pkg::*;

  localparam int AW    = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int XW    = (AW > IDX_W) ? AW : IDX_W;
  localparam int POS3W = 3 * POS_W;
  localparam int RUN2W = 2 * RUN_W;

  logic [THR_W-1:0]       thr_q;
  logic [MAX_SENSORS-1:0] primed_q;

  logic                   s1_valid_q;
  logic [AW-1:0]          s1_addr_q;
  logic [IDX_W-1:0]       s1_sensor_q;
  msd_pos_t               s1_pos_q;

  logic                   fwd_q;
  msd_pos_t               fwd_ref_q;
  logic [RUN2W-1:0]       fwd_run_q;

  logic                   out_valid_q;
  msd_out_t               out_req_q;

  logic                   accept;
  logic                   in_range;
  logic [XW-1:0]          idx_ext;
  logic [AW-1:0]          in_addr;
  logic                   s1_adv;
  logic                   wr_en;

  logic [POS3W-1:0]       ref_rd;
  logic [RUN2W-1:0]       run_rd;
  msd_pos_t               cur_ref;
  logic [RUN2W-1:0]       cur_run;
  msd_pos_t               new_ref;
  logic [RUN_W-1:0]       new_move;
  logic [RUN_W-1:0]       new_still;
  logic [RUN2W-1:0]       new_run;
  logic                   evt_valid;
  msd_out_t               evt;
  msd_pos_t               in_pos;

  assign idx_ext  = XW'(in_req_i.sensor_index);
  assign in_addr  = idx_ext[AW-1:0];
  assign in_range = 32'(in_req_i.sensor_index) < 32'(MAX_SENSORS);
  assign in_pos   = '{x: in_req_i.pos_x, y: in_req_i.pos_y, z: in_req_i.pos_z};

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;
  assign wr_en      = s1_valid_q && s1_adv;

  assign cur_ref = fwd_q ? fwd_ref_q : msd_pos_t'(ref_rd);
  assign cur_run = fwd_q ? fwd_run_q : run_rd;
  assign new_run = {new_move, new_still};

  msd_ram #(
    .WIDTH (POS3W),
    .DEPTH (MAX_SENSORS),
    .AW    (AW)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (POS3W'(new_ref)),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (ref_rd)
  );

  msd_ram #(
    .WIDTH (RUN2W),
    .DEPTH (MAX_SENSORS),
    .AW    (AW)
  ) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (new_run),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (run_rd)
  );

  msd_eval #(
    .RUN_W (RUN_W)
  ) u_eval (
    .thr_i       (thr_q),
    .sensor_i    (s1_sensor_q),
    .pos_i       (s1_pos_q),
    .primed_i    (primed_q[s1_addr_q]),
    .ref_i       (cur_ref),
    .move_i      (cur_run[RUN2W-1:RUN_W]),
    .still_i     (cur_run[RUN_W-1:0]),
    .ref_o       (new_ref),
    .move_o      (new_move),
    .still_o     (new_still),
    .evt_valid_o (evt_valid),
    .evt_o       (evt)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THRESH_RESET;
      primed_q    <= '0;
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        primed_q[s1_addr_q] <= 1'b1;
      end
      if (accept) begin
        s1_valid_q <= in_range;
        // entry written at the same edge as the read
        fwd_q      <= wr_en && (s1_addr_q == in_addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q && evt_valid;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q   <= in_addr;
      s1_sensor_q <= in_req_i.sensor_index;
      s1_pos_q    <= in_pos;
      fwd_ref_q   <= new_ref;
      fwd_run_q   <= new_run;
    end
    if (s1_adv) begin
      out_req_q <= evt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule
